[rtl/core/vtm_pkg.sv]
// Vertex transform package: shared types, command codes, constants and sat32().
// No dependencies.
`default_nettype none
package vtm_pkg;
    typedef enum logic {
        CMD_WRITE  = 1'b0,
        CMD_VERTEX = 1'b1
    } t_cmd;

    localparam logic [1:0] SEL_MODEL = 2'd0;
    localparam logic [1:0] SEL_VIEW  = 2'd1;
    localparam logic [1:0] SEL_PROJ  = 2'd2;
    localparam logic [1:0] SEL_NONE  = 2'd3;

    typedef struct packed {
        logic                 is_vertex;
        logic [1:0]           mat_select;
        logic [3:0]           elem_index;
        logic signed [31:0]   elem_value;
        logic signed [31:0]   pos_x;
        logic signed [31:0]   pos_y;
        logic signed [31:0]   pos_z;
        logic signed [31:0]   nrm_x;
        logic signed [31:0]   nrm_y;
        logic signed [31:0]   nrm_z;
        logic [63:0]          tex;
    } t_item;

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [31:0] clip_x;
        logic signed [31:0] clip_y;
        logic signed [31:0] clip_z;
        logic signed [31:0] clip_w;
        logic [63:0]        tex_out;
        logic               singular;
    } t_result;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/core/vertex_transform_mvp_top.sv]
// Top level of the vertex transform block: front queue plus back-end sequencer.
// Depends on vtm_pkg, vtm_front, vtm_back.
//
//  channel | handshake            | payload
//  input   | i_valid / o_ready    | i_cmd .. i_tex_in
//  output  | o_valid / i_ready    | o_world_* .. o_singular
//
// A vertex needs 57 products, issued one at a time through the one shared
// multiply-accumulate. Rebuilding the normal matrix adds 90 cofactor products,
// 4 determinant products and nine divides. Reset is synchronous; the matrix
// store reads as identity until written. A waiting result holds only the final
// output step; either side may stall on its own.
`default_nettype none
module vertex_transform_mvp_top
    import vtm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_cmd,
    input  wire logic [1:0]         i_mat_select,
    input  wire logic [3:0]         i_elem_index,
    input  wire logic signed [31:0] i_elem_value,
    input  wire logic signed [31:0] i_pos_x,
    input  wire logic signed [31:0] i_pos_y,
    input  wire logic signed [31:0] i_pos_z,
    input  wire logic signed [31:0] i_nrm_x,
    input  wire logic signed [31:0] i_nrm_y,
    input  wire logic signed [31:0] i_nrm_z,
    input  wire logic [63:0]        i_tex_in,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_world_x,
    output logic signed [31:0]      o_world_y,
    output logic signed [31:0]      o_world_z,
    output logic signed [31:0]      o_normal_x,
    output logic signed [31:0]      o_normal_y,
    output logic signed [31:0]      o_normal_z,
    output logic signed [31:0]      o_clip_x,
    output logic signed [31:0]      o_clip_y,
    output logic signed [31:0]      o_clip_z,
    output logic signed [31:0]      o_clip_w,
    output logic [63:0]             o_tex_out,
    output logic                    o_singular
);
    t_item   w_item;
    t_item   w_q_item;
    logic    w_q_valid;
    logic    w_q_pop;
    t_result w_res;

    assign w_item = '{is_vertex: (i_cmd == CMD_VERTEX), mat_select: i_mat_select,
                      elem_index: i_elem_index, elem_value: i_elem_value,
                      pos_x: i_pos_x, pos_y: i_pos_y, pos_z: i_pos_z,
                      nrm_x: i_nrm_x, nrm_y: i_nrm_y, nrm_z: i_nrm_z, tex: i_tex_in};

    vtm_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_item    (w_item),
        .o_q_valid (w_q_valid),
        .i_q_pop   (w_q_pop),
        .o_q_item  (w_q_item)
    );

    vtm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .o_q_pop   (w_q_pop),
        .i_q_item  (w_q_item),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_res     (w_res)
    );

    assign o_world_x  = w_res.world_x;
    assign o_world_y  = w_res.world_y;
    assign o_world_z  = w_res.world_z;
    assign o_normal_x = w_res.normal_x;
    assign o_normal_y = w_res.normal_y;
    assign o_normal_z = w_res.normal_z;
    assign o_clip_x   = w_res.clip_x;
    assign o_clip_y   = w_res.clip_y;
    assign o_clip_z   = w_res.clip_z;
    assign o_clip_w   = w_res.clip_w;
    assign o_tex_out  = w_res.tex_out;
    assign o_singular = w_res.singular;
endmodule
`default_nettype wire

[rtl/core/vtm_front.sv]
// Front end: accepts transactions, drops writes to SEL_NONE, queues the rest (two entries).
// Depends on vtm_pkg.
`default_nettype none
module vtm_front
    import vtm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_item       i_item,
    output logic             o_q_valid,
    input  wire logic        i_q_pop,
    output t_item            o_q_item
);
    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_drop;

    assign o_ready   = (r_cnt != 2'd2);
    assign w_drop    = !i_item.is_vertex && (i_item.mat_select == SEL_NONE);
    assign w_push    = i_valid && o_ready && !w_drop;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

[rtl/core/vtm_div.sv]
// Radix-2 restoring divider: signed 64 by 32 quotient, truncated toward zero.
// Depends on vtm_pkg.
`default_nettype none
module vtm_div
    import vtm_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [63:0]      o_quot
);
    logic [63:0] r_q;
    logic [32:0] r_rem;
    logic [31:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [33:0] w_trial;
    logic [32:0] w_sh;
    logic [63:0] w_qn;

    assign w_sh    = {r_rem[31:0], r_q[63]};
    assign w_trial = {1'b0, w_sh} - {2'b00, r_den};
    assign w_qn    = {r_q[62:0], ~w_trial[33]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= 7'd0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
                r_q    <= i_num[63] ? -i_num : i_num;
                r_den  <= i_den[31] ? -i_den : i_den;
                r_neg  <= i_num[63] ^ i_den[31];
                r_rem  <= 33'd0;
            end else if (r_busy) begin
                r_q   <= w_qn;
                r_rem <= w_trial[33] ? w_sh : w_trial[32:0];
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

[rtl/core/vtm_back.sv]
// Back end: matrix store, shared rounding multiply-accumulate, normal-matrix rebuild
// and vertex transform sequencer. Depends on vtm_pkg and vtm_div.
`default_nettype none
module vtm_back
    import vtm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_q_valid,
    output logic         o_q_pop,
    input  wire t_item   i_q_item,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);
    localparam logic signed [31:0] ONE  = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_COF, S_DET, S_DIVS, S_DIVW, S_XF, S_OUT
    } t_state;

    t_state             r_state;
    logic signed [31:0] r_m   [48];
    logic               r_mval[48];
    logic signed [31:0] r_n   [9];
    logic signed [31:0] r_cof [16];
    logic               r_stale;
    logic               r_sing;
    t_item              r_it;
    logic signed [31:0] r_v   [15];
    logic [2:0]         r_ph;
    logic [4:0]         r_j;
    logic [3:0]         r_k;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_mn  [3];
    logic signed [31:0] r_det;
    logic signed [31:0] r_a, r_b;
    logic               r_mv;
    logic               r_sub;
    logic               r_pv;
    logic               r_psub;
    logic               r_dst;
    logic signed [63:0] w_prod;
    logic signed [63:0] w_rp;
    logic signed [63:0] w_rnd;
    logic               w_dd;
    logic signed [63:0] w_q;
    logic [3:0]         r_ci;
    logic [3:0]         r_ni;
    logic signed [31:0] w_ncof;

    // position of normal-matrix entry ni (row-major 3x3) in the cofactor store
    function automatic logic [3:0] cof_idx(input logic [3:0] ni);
        logic [3:0] r;
        case (ni)
            4'd0: r = 4'd0;
            4'd1: r = 4'd1;
            4'd2: r = 4'd2;
            4'd3: r = 4'd4;
            4'd4: r = 4'd5;
            4'd5: r = 4'd6;
            4'd6: r = 4'd8;
            4'd7: r = 4'd9;
            4'd8: r = 4'd10;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    assign w_ncof = r_cof[cof_idx(r_ni)];

    vtm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dst),
        .i_num   ({{(32-FRAC_BITS){w_ncof[31]}}, w_ncof, {FRAC_BITS{1'b0}}}),
        .i_den   (r_det),
        .o_done  (w_dd),
        .o_quot  (w_q)
    );

    // element read with identity reset
    function automatic logic signed [31:0] rd(
        input logic signed [31:0] v, input logic ok, input logic [3:0] e);
        logic signed [31:0] r;
        if (ok) begin
            r = v;
        end else begin
            r = (e == 4'd0 || e == 4'd5 || e == 4'd10 || e == 4'd15) ? ONE : 32'sd0;
        end
        return r;
    endfunction

    assign w_prod = r_a * r_b;
    assign w_rnd  = w_prod + HALF;
    assign w_rp   = w_rnd >>> FRAC_BITS;

    // model element (row i, col j) of the 3x3 minor taken for cofactor ci
    function automatic logic [3:0] sub_idx(input logic [3:0] ci, input logic [1:0] i,
                                           input logic [1:0] j);
        logic [1:0] sr, sc, rr, cc;
        sr = ci[3:2];
        sc = ci[1:0];
        rr = (i >= sr) ? i + 2'd1 : i;
        cc = (j >= sc) ? j + 2'd1 : j;
        return {cc, rr};
    endfunction

    function automatic logic [5:0] me_addr(input logic [3:0] ci, input logic [1:0] i,
                                           input logic [1:0] j);
        return {2'b00, sub_idx(ci, i, j)};
    endfunction

    // schedule step: operands for product r_k of phase r_ph
    logic signed [31:0] w_oa, w_ob;
    logic [5:0]         w_ea, w_eb;
    logic               w_am, w_bm;
    logic               w_osub, w_olast;
    always_comb begin
        logic [1:0] rr, cc;
        w_oa = 32'sd0;
        w_ob = 32'sd0;
        w_ea = 6'd0;
        w_eb = 6'd0;
        w_am = 1'b0;
        w_bm = 1'b0;
        w_osub = 1'b0;
        w_olast = 1'b0;
        rr = r_j[1:0];
        cc = r_k[1:0];
        case (r_state)
            S_COF: begin
                w_am = 1'b1;
                case (r_ph)
                    3'd0: begin
                        w_bm = 1'b1;
                        w_ea = (r_k == 4'd0) ? me_addr(r_ci, 2'd1, 2'd1) :
                                               me_addr(r_ci, 2'd1, 2'd2);
                        w_eb = (r_k == 4'd0) ? me_addr(r_ci, 2'd2, 2'd2) :
                                               me_addr(r_ci, 2'd2, 2'd1);
                        w_osub = (r_k != 4'd0); w_olast = (r_k == 4'd1);
                    end
                    3'd1: begin
                        w_bm = 1'b1;
                        w_ea = (r_k == 4'd0) ? me_addr(r_ci, 2'd1, 2'd0) :
                                               me_addr(r_ci, 2'd1, 2'd2);
                        w_eb = (r_k == 4'd0) ? me_addr(r_ci, 2'd2, 2'd2) :
                                               me_addr(r_ci, 2'd2, 2'd0);
                        w_osub = (r_k != 4'd0); w_olast = (r_k == 4'd1);
                    end
                    3'd2: begin
                        w_bm = 1'b1;
                        w_ea = (r_k == 4'd0) ? me_addr(r_ci, 2'd1, 2'd0) :
                                               me_addr(r_ci, 2'd1, 2'd1);
                        w_eb = (r_k == 4'd0) ? me_addr(r_ci, 2'd2, 2'd1) :
                                               me_addr(r_ci, 2'd2, 2'd0);
                        w_osub = (r_k != 4'd0); w_olast = (r_k == 4'd1);
                    end
                    default: begin
                        w_ea = me_addr(r_ci, 2'd0, cc);
                        w_ob = r_mn[cc];
                        w_osub = (r_k == 4'd1); w_olast = (r_k == 4'd2);
                    end
                endcase
            end
            S_DET: begin
                w_am = 1'b1;
                w_ea = {2'b00, cc, 2'b00};
                w_ob = r_cof[{2'b00, cc}];
                w_olast = (r_k == 4'd3);
            end
            S_XF: begin
                w_olast = (r_k == 4'd3);
                case (r_ph)
                    3'd0: begin
                        w_am = 1'b1;
                        w_ea = {2'b00, cc, rr};
                        w_ob = (cc == 2'd0) ? r_it.pos_x : (cc == 2'd1) ? r_it.pos_y :
                               (cc == 2'd2) ? r_it.pos_z : ONE;
                    end
                    3'd1: begin
                        w_am = 1'b1;
                        w_ea = {2'b01, cc, rr};
                        w_ob = (cc == 2'd3) ? ONE : r_v[{2'b00, cc}];
                    end
                    3'd2: begin
                        w_am = 1'b1;
                        w_ea = {2'b10, cc, rr};
                        w_ob = r_v[{2'b01, cc}];
                    end
                    default: begin
                        w_oa = r_n[{2'b00, rr} * 4'd3 + {2'b00, cc}];
                        w_ob = (cc == 2'd0) ? r_it.nrm_x : (cc == 2'd1) ? r_it.nrm_y :
                               r_it.nrm_z;
                        w_olast = (r_k == 4'd2);
                    end
                endcase
            end
            default: ;
        endcase
    end

    logic r_plast;
    logic signed [63:0] w_sum;
    assign w_sum = r_psub ? r_acc - w_rp : r_acc + w_rp;

    always_ff @(posedge i_clk) begin
        r_a   <= w_am ? rd(r_m[w_ea], r_mval[w_ea], w_ea[3:0]) : w_oa;
        r_b   <= w_bm ? rd(r_m[w_eb], r_mval[w_eb], w_eb[3:0]) : w_ob;
        r_sub <= w_osub;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stale <= 1'b0;
            r_sing  <= 1'b0;
            o_valid <= 1'b0;
            o_q_pop <= 1'b0;
            r_mv    <= 1'b0;
            r_pv    <= 1'b0;
            r_dst   <= 1'b0;
            for (int i = 0; i < 48; i++) begin
                r_mval[i] <= 1'b0;
            end
            for (int i = 0; i < 9; i++) begin
                r_n[i] <= (i % 4 == 0) ? ONE : 32'sd0;
            end
        end else begin
            o_q_pop <= 1'b0;
            r_dst   <= 1'b0;
            r_mv    <= 1'b0;
            r_pv    <= r_mv;
            r_psub  <= r_sub;
            r_plast <= w_olast & r_mv;
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && !o_q_pop) begin
                        o_q_pop <= 1'b1;
                        r_it    <= i_q_item;
                        if (!i_q_item.is_vertex) begin
                            r_m[{i_q_item.mat_select, i_q_item.elem_index}] <=
                                i_q_item.elem_value;
                            r_mval[{i_q_item.mat_select, i_q_item.elem_index}] <= 1'b1;
                            if (i_q_item.mat_select == SEL_MODEL) begin
                                r_stale <= 1'b1;
                            end
                        end else begin
                            r_acc <= 64'sd0;
                            r_k   <= 4'd0;
                            r_j   <= 5'd0;
                            r_ph  <= 3'd0;
                            r_ci  <= 4'd0;
                            r_state <= r_stale ? S_COF : S_XF;
                        end
                    end
                end
                default: ;
            endcase
            if (r_state == S_COF || r_state == S_DET || r_state == S_XF) begin
                // issue one product, wait for it to retire before the next
                if (!r_mv && !r_pv) begin
                    r_mv <= 1'b1;
                end
                if (r_pv) begin
                    r_acc <= 64'sd0;
                    if (!r_plast) begin
                        r_acc <= w_sum;
                        r_k   <= r_k + 4'd1;
                    end else begin
                        r_k <= 4'd0;
                        case (r_state)
                            S_COF: begin
                                if (r_ph != 3'd3) begin
                                    r_mn[r_ph[1:0]] <= sat32(w_sum);
                                    r_ph <= r_ph + 3'd1;
                                end else begin
                                    r_cof[r_ci] <= (r_ci[0] ^ r_ci[2]) ?
                                        sat32(-{{32{w_sum[63]}}, sat32(w_sum)}) : sat32(w_sum);
                                    r_ph <= 3'd0;
                                    if (r_ci == 4'd3) begin
                                        r_state <= S_DET;
                                    end else if (r_ci[1:0] == 2'd3) begin
                                        r_ci <= r_ci + 4'd1;
                                    end else if (r_ci == 4'd2 || r_ci == 4'd6) begin
                                        r_ci <= r_ci + 4'd2;
                                    end else if (r_ci == 4'd10) begin
                                        r_ci <= 4'd3;
                                    end else begin
                                        r_ci <= r_ci + 4'd1;
                                    end
                                end
                            end
                            S_DET: begin
                                r_det <= sat32(w_sum);
                                r_stale <= 1'b0;
                                if (sat32(w_sum) == 32'sd0) begin
                                    r_sing <= 1'b1;
                                    for (int i = 0; i < 9; i++) begin
                                        r_n[i] <= 32'sd0;
                                    end
                                    r_state <= S_XF;
                                end else begin
                                    r_sing <= 1'b0;
                                    r_ni   <= 4'd0;
                                    r_state <= S_DIVS;
                                end
                            end
                            default: begin
                                if (r_ph == 3'd3) begin
                                    r_v[4'd12 + {2'b00, r_j[1:0]}] <= sat32(w_sum);
                                end else begin
                                    r_v[{r_ph[1:0], r_j[1:0]}] <= sat32(w_sum);
                                end
                                if ((r_ph == 3'd3 && r_j == 5'd2) ||
                                    (r_ph != 3'd3 && r_j == 5'd3)) begin
                                    r_j <= 5'd0;
                                    if (r_ph == 3'd3) begin
                                        r_state <= S_OUT;
                                    end
                                    r_ph <= r_ph + 3'd1;
                                end else begin
                                    r_j <= r_j + 5'd1;
                                end
                            end
                        endcase
                    end
                end
            end
            if (r_state == S_DIVS) begin
                r_dst   <= 1'b1;
                r_state <= S_DIVW;
            end
            if (r_state == S_DIVW && w_dd) begin
                r_n[r_ni] <= sat32(w_q);
                if (r_ni == 4'd8) begin
                    r_state <= S_XF;
                    r_ph    <= 3'd0;
                    r_j     <= 5'd0;
                end else begin
                    r_ni    <= r_ni + 4'd1;
                    r_state <= S_DIVS;
                end
            end
            if (r_state == S_OUT && !o_valid) begin
                o_valid <= 1'b1;
                o_res.world_x  <= r_v[0];
                o_res.world_y  <= r_v[1];
                o_res.world_z  <= r_v[2];
                o_res.normal_x <= r_v[12];
                o_res.normal_y <= r_v[13];
                o_res.normal_z <= r_v[14];
                o_res.clip_x   <= r_v[8];
                o_res.clip_y   <= r_v[9];
                o_res.clip_z   <= r_v[10];
                o_res.clip_w   <= r_v[11];
                o_res.tex_out  <= r_it.tex;
                o_res.singular <= r_sing;
                r_state <= S_IDLE;
            end
        end
    end
endmodule
`default_nettype wire
